[rtl/core/lkvc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the LRU key-value cache core.
// No dependencies; imported by every module of the block.
package lkvc_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   // One cache entry as it travels along the cell chain.
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } entry_type;

   // Per-cell load controls.
   typedef struct packed {
      logic take_front;
      logic take_prev;
   } cell_ctrl_type;

endpackage

[rtl/core/lkvc_cell.sv]
`timescale 1ns / 1ps
// One slot of the recency-ordered chain: holds an entry and compares its key.
// Depends on lkvc_pkg.
module lkvc_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  lkvc_pkg::cell_ctrl_type    ctrl,
   input  lkvc_pkg::entry_type        front,
   input  lkvc_pkg::entry_type        prev,
   input  logic [lkvc_pkg::KEY_W-1:0] probe_key,
   output lkvc_pkg::entry_type        entry,
   output logic                       match
);
   import lkvc_pkg::*;

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] value_ff, value_in;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (ctrl.take_front) begin
         valid_in = front.valid;
         key_in   = front.key;
         value_in = front.value;
      end else if (ctrl.take_prev) begin
         valid_in = prev.valid;
         key_in   = prev.key;
         value_in = prev.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset; it is only read behind the valid bit.
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign entry.valid = valid_ff;
   assign entry.key   = key_ff;
   assign entry.value = value_ff;
   assign match       = valid_ff && (key_ff == probe_key);

endmodule

[rtl/core/lru_key_value_cache_core.sv]
`timescale 1ns / 1ps
// Top level of the LRU key-value cache: cell chain, hit select, result register.
// Depends on lkvc_pkg and lkvc_cell.
//
//   channel | ports                                              | direction
//   --------+----------------------------------------------------+----------
//   request | req_valid req_stall req_op req_lookup_key           | in
//           | req_store_value                                    |
//   result  | rsp_valid rsp_stall rsp_hit rsp_read_value         | out
//   csr     | csr_valid csr_ready csr_data (capacity_in_use)     | in
//
// Cycles: one request per clock while req_stall is low. A get's result appears in
//   the result register the cycle after acceptance; the whole lookup, recency update
//   and replacement complete together through the parallel key compare in every cell.
// Reset: clears all valid bits, including the result register's, and sets capacity to 16.
// Stalls: a request is stalled only while a held result is itself stalled.
//
// Organization: cell 0 holds the most recent entry, cell N-1 the least recent.
// Valid entries always fill a prefix of the chain. An update loads cell 0 with
// the touched/new entry and shifts the cells above it down by one.
module lru_key_value_cache_core #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic signed [lkvc_pkg::KEY_W-1:0] req_lookup_key,
   input  logic signed [lkvc_pkg::VAL_W-1:0] req_store_value,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic signed [lkvc_pkg::VAL_W-1:0] rsp_read_value,
   // capacity register
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0]        csr_data
);
   import lkvc_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   // capacity register
   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CNT_W-1:0] cap_eff;
   logic [IDX_W-1:0] cap_last;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;

   // chain
   entry_type                    cells   [MAX_ENTRIES];
   cell_ctrl_type                ctrl    [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]       match_vec;
   logic [MAX_ENTRIES-1:0]       valid_vec;
   logic [MAX_ENTRIES-1:0]       at_or_above_hit;
   entry_type                    front;
   logic                         accept;
   logic                         is_put;
   logic                         any_hit;
   logic                         full;
   logic                         update;
   logic [VAL_W-1:0]             hit_value;

   assign csr_ready   = 1'b1;
   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign accept      = req_valid && !req_stall;
   assign is_put      = (req_op == OP_PUT);

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_valid && csr_ready) begin
         capacity_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // Zero means one; anything above the chain length saturates.
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (int'(capacity_ff) > MAX_ENTRIES) begin
         cap_eff = CNT_W'(MAX_ENTRIES);
      end else begin
         cap_eff = CNT_W'(capacity_ff);
      end
      cap_last = IDX_W'(cap_eff - CNT_W'(1));
   end

   // Fill level reaches capacity when the slot at capacity-1 is occupied.
   assign full = valid_vec[cap_last];

   always_comb begin
      any_hit   = |match_vec;
      hit_value = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (match_vec[i]) begin
            hit_value = hit_value | cells[i].value;
         end
         at_or_above_hit[i] = |(match_vec >> i);
      end
   end

   // Gets that miss leave the chain untouched.
   assign update = accept && (is_put || any_hit);

   always_comb begin
      front.valid = 1'b1;
      front.key   = req_lookup_key;
      front.value = is_put ? req_store_value : hit_value;
   end

   // Shift extent: up to the hit slot; on an insert, up to the tail (evicting
   // it when full) or one past it (growing the fill).
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         ctrl[i].take_front = (i == 0) && update;
         ctrl[i].take_prev  = 1'b0;
      end
      for (int i = 1; i < MAX_ENTRIES; i++) begin
         if (any_hit) begin
            ctrl[i].take_prev = update && at_or_above_hit[i];
         end else if (full) begin
            ctrl[i].take_prev = update && valid_vec[i];
         end else begin
            ctrl[i].take_prev = update && valid_vec[i-1];
         end
      end
   end

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
         lkvc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl[g]),
            .front     (front),
            .prev      (front),
            .probe_key (req_lookup_key),
            .entry     (cells[g]),
            .match     (match_vec[g])
         );
      end else begin : g_body
         lkvc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl[g]),
            .front     (front),
            .prev      (cells[g-1]),
            .probe_key (req_lookup_key),
            .entry     (cells[g]),
            .match     (match_vec[g])
         );
      end
      assign valid_vec[g] = cells[g].valid;
   end

   // Result register: loads on an accepted get, drains when not stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      if (accept && !is_put) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = any_hit;
         rsp_value_in = any_hit ? hit_value : '0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

[rtl/core/lkvc_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the LRU key-value cache core, plus the bind.
// Depends on lkvc_pkg and lru_key_value_cache_core.
module lkvc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_op,
   input logic signed [lkvc_pkg::KEY_W-1:0] req_lookup_key,
   input logic signed [lkvc_pkg::VAL_W-1:0] req_store_value,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_hit,
   input logic signed [lkvc_pkg::VAL_W-1:0] rsp_read_value
);
   import lkvc_pkg::*;

   logic put_acc, get_acc;
   assign put_acc = req_valid && !req_stall && (req_op == OP_PUT);
   assign get_acc = req_valid && !req_stall && (req_op == OP_GET);

   // Held result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value))
      else $error("result changed while stalled");

   // A miss reports zero data.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_read_value == '0)
      else $error("miss with nonzero data");

   // Every accepted get yields a result on the next cycle.
   a_get_result: assert property (@(posedge clock) disable iff (reset)
      get_acc |=> rsp_valid)
      else $error("accepted get produced no result");

   // A put followed directly by a get of the same key must hit with that value.
   a_put_get: assert property (@(posedge clock) disable iff (reset)
      put_acc ##1 (get_acc && req_lookup_key == $past(req_lookup_key))
      |=> rsp_hit && rsp_read_value == $past(req_store_value, 2))
      else $error("fresh put not visible to next get");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_op          (req_op),
   .req_lookup_key  (req_lookup_key),
   .req_store_value (req_store_value),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_hit         (rsp_hit),
   .rsp_read_value  (rsp_read_value)
);

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache_core: a scoreboard class mirrors the
// LRU store and checks every get result. Depends on lkvc_pkg and the core RTL only.
module testbench;
   import lkvc_pkg::*;

   localparam int SLOTS        = 16;        // must match the core's MAX_ENTRIES
   localparam int LONG_HOLD    = 200;       // receiver hold-off used to back up the core
   localparam int CYCLE_LIMIT  = 1_000_000; // hard stop, far above the slowest good run
   localparam int DRAIN_CYCLES = 8;         // quiet cycles after the last result
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 150;

   // Expected outcome of one get.
   typedef struct {
      bit                      hit;
      logic signed [VAL_W-1:0] value;
   } lookup_reply_type;

   // Mirror of the cache: keys, values, valid bits and recency ranks (0 = most
   // recent), plus the queue of get results still owed by the core.
   class cache_mirror_type;
      logic [KEY_W-1:0] keys[SLOTS];
      logic [VAL_W-1:0] vals[SLOTS];
      bit               valid[SLOTS];
      int unsigned      rank[SLOTS];
      logic [CAP_W-1:0] capacity;
      lookup_reply_type awaited_replies[$];
      int               errors, gets, hits, puts, evictions, cap_writes;

      function new();
         foreach (valid[i]) begin
            valid[i] = 1'b0;
            rank[i]  = 0;
            keys[i]  = '0;
            vals[i]  = '0;
         end
         capacity   = CAP_RESET;
         errors     = 0;
         gets       = 0;
         hits       = 0;
         puts       = 0;
         evictions  = 0;
         cap_writes = 0;
      endfunction

      function void set_capacity(input logic [CAP_W-1:0] cap);
         capacity = cap;
         cap_writes++;
      endfunction

      // Zero acts as one; anything above the store size saturates.
      function int usable_slots();
         int c = int'(capacity);
         if (c == 0) c = 1;
         if (c > SLOTS) c = SLOTS;
         return c;
      endfunction

      function int find_slot(input logic [KEY_W-1:0] key);
         for (int i = 0; i < SLOTS; i++)
            if (valid[i] && keys[i] === key) return i;
         return -1;
      endfunction

      // Entries more recent than idx age by one; idx becomes most recent.
      function void promote(input int idx);
         int unsigned r = rank[idx];
         for (int i = 0; i < SLOTS; i++)
            if (valid[i] && rank[i] < r) rank[i]++;
         rank[idx] = 0;
      endfunction

      function void store_new(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] value);
         int fill = 0;
         int slot = -1;
         int unsigned worst = 0;
         foreach (valid[i]) if (valid[i]) fill++;
         if (fill >= usable_slots()) begin
            // full (or over a lowered capacity): overwrite the least recent entry
            for (int i = 0; i < SLOTS; i++)
               if (valid[i] && (slot < 0 || rank[i] > worst)) begin
                  slot  = i;
                  worst = rank[i];
               end
            keys[slot] = key;
            vals[slot] = value;
            promote(slot);
            evictions++;
            return;
         end
         for (int i = 0; i < SLOTS; i++)
            if (!valid[i] && slot < 0) slot = i;
         for (int i = 0; i < SLOTS; i++)
            if (valid[i]) rank[i]++;
         keys[slot]  = key;
         vals[slot]  = value;
         valid[slot] = 1'b1;
         rank[slot]  = 0;
      endfunction

      // Called for every accepted request.
      function void note_request(input op_type op, input logic [KEY_W-1:0] key,
                                 input logic [VAL_W-1:0] value);
         int idx = find_slot(key);
         lookup_reply_type r;
         if (op == OP_GET) begin
            gets++;
            if (idx >= 0) begin
               promote(idx);
               r.hit   = 1'b1;
               r.value = vals[idx];
               hits++;
            end else begin
               r.hit   = 1'b0;
               r.value = '0;
            end
            awaited_replies.push_back(r);
         end else begin
            puts++;
            if (idx >= 0) begin
               vals[idx] = value;
               promote(idx);
            end else begin
               store_new(key, value);
            end
         end
      endfunction

      // Called for every accepted result.
      function void check_reply(input logic hit, input logic signed [VAL_W-1:0] value);
         lookup_reply_type r;
         if (awaited_replies.size() == 0) begin
            $error("result with no get outstanding: hit %b read_value %0d", hit, value);
            errors++;
            return;
         end
         r = awaited_replies.pop_front();
         if (hit !== r.hit) begin
            $error("hit: expected %b, got %b", r.hit, hit);
            errors++;
         end
         if (value !== r.value) begin
            $error("read_value: expected %0d, got %0d", r.value, value);
            errors++;
         end
      endfunction

      function int pending();
         return awaited_replies.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_op;
   logic signed [KEY_W-1:0]  req_lookup_key;
   logic signed [VAL_W-1:0]  req_store_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_hit;
   logic signed [VAL_W-1:0]  rsp_read_value;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CAP_W-1:0]         csr_data;

   cache_mirror_type mirror = new();

   int  cycle_count = 0;
   int  holds_asked = 0;   // bumped by the sender side to request a long receiver hold-off
   bit  rx_steady   = 1'b0; // receiver takes every result while set

   lru_key_value_cache_core #(
      .MAX_ENTRIES(SLOTS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_lookup_key (req_lookup_key),
      .req_store_value(req_store_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case a handshake never completes.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, mirror.pending());
         $display("lru_key_value_cache_core test failed");
         $finish;
      end
   end

   // Monitor: all stimulus changes through nonblocking assignments, so at the
   // edge these reads see the values the core itself samples.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            mirror.note_request(op_type'(req_op), req_lookup_key, req_store_value);
         if (rsp_valid && !rsp_stall)
            mirror.check_reply(rsp_hit, rsp_read_value);
         if (csr_valid && csr_ready)
            mirror.set_capacity(csr_data);
      end
   end

   // Mostly no gap, some short ones, a few long ones.
   function automatic int pick_gap();
      int roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Result side: random stall bursts, plus a long hold-off whenever the sender
   // asks for one. Each pass drives rsp_stall and then advances time.
   initial begin
      int holds_done;
      int stall_len;
      holds_done = 0;
      rsp_stall  = 1'b0;
      forever begin
         if (holds_done != holds_asked) begin
            holds_done = holds_asked;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            stall_len = rx_steady ? 0 : pick_gap();
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clock);
         end
      end
   end

   // Offer one request and hold it until the core takes it. Called at a rising
   // edge; returns at the edge where the request was accepted.
   task automatic send_request(input op_type op, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] value);
      req_valid       <= 1'b1;
      req_op          <= op;
      req_lookup_key  <= key;
      req_store_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stop offering requests until every get has been answered. The count is
   // read at the falling edge, clear of the monitor's updates.
   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(negedge clock); while (mirror.pending() != 0);
      @(posedge clock);
   endtask

   // Capacity writes only with the core idle: drained, and then held off further so
   // a trailing put has settled.
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      drain_replies();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Edge keys and values, one-bit-apart keys, update of a live key, and the
   // capacity corner cases: lowered below fill, zero, above the store size.
   task automatic run_directed();
      send_request(OP_GET, 32'h0000_0000, $urandom);      // miss on an empty store
      send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_GET, 32'h8000_0000, $urandom);
      send_request(OP_GET, 32'h7FFF_FFFF, $urandom);
      send_request(OP_GET, 32'h0000_0001, $urandom);      // one bit off a stored key
      send_request(OP_GET, 32'hFFFF_FFFF, $urandom);
      send_request(OP_PUT, 32'h0000_0000, 32'h5A5A_A5A5); // overwrite in place
      send_request(OP_GET, 32'h0000_0000, $urandom);
      send_request(OP_GET, 32'h7FFF_FFFE, $urandom);
      write_capacity(5'd2);                               // below the current fill
      send_request(OP_PUT, 32'h0000_0011, 32'h0000_0001);
      send_request(OP_GET, 32'h8000_0000, $urandom);
      send_request(OP_GET, 32'h0000_0011, $urandom);
      send_request(OP_GET, 32'hFFFF_FFFF, $urandom);
      write_capacity(5'd0);                               // acts as one entry
      send_request(OP_PUT, 32'h0000_0022, 32'h0000_0002);
      send_request(OP_PUT, 32'h0000_0033, 32'h0000_0003);
      send_request(OP_GET, 32'h0000_0022, $urandom);
      send_request(OP_GET, 32'h0000_0033, $urandom);
      write_capacity(5'd31);                              // saturates at the store size
      send_request(OP_PUT, 32'h0000_0044, 32'h0000_0004);
      send_request(OP_GET, 32'h0000_0033, $urandom);
      send_request(OP_GET, 32'h0000_0044, $urandom);
   endtask

   // Random traffic over a small key set so hits and evictions are common;
   // some fully random keys and values toggle every bit.
   task automatic run_traffic(input int count, input int put_pct, input bit steady,
                              input int hold_at);
      logic [KEY_W-1:0] key_set[24];
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      int               set_size;
      op_type           op;
      set_size = $urandom_range(24, 3);
      foreach (key_set[i]) begin
         case ($urandom_range(7))
            0:       key_set[i] = (i == 0) ? $urandom
                                           : key_set[0] ^ (32'h1 << $urandom_range(31));
            1:       key_set[i] = ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: key_set[i] = $urandom;
         endcase
      end
      rx_steady <= steady;
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) holds_asked <= holds_asked + 1;
         op  = ($urandom_range(99) < put_pct) ? OP_PUT : OP_GET;
         key = ($urandom_range(99) < 85) ? key_set[$urandom_range(set_size - 1)] : $urandom;
         case ($urandom_range(15))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = 32'hFFFF_FFFF;
            3:       value = 32'h0000_0000;
            default: value = $urandom;
         endcase
         send_request(op, key, value);
         if (!steady) pause_sender(pick_gap());
      end
      rx_steady <= 1'b0;
   endtask

   initial begin
      logic [CAP_W-1:0] cap_plan[PHASES];
      cap_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd8, 5'd3, 5'd2, 5'd15,
                   5'd0, 5'd0, 5'd0};
      for (int p = 9; p < PHASES; p++) cap_plan[p] = $urandom_range(31);

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_GET;
      req_lookup_key  = '0;
      req_store_value = '0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_capacity(CAP_RESET);
      run_directed();

      // Phases at different capacities; some with no idling on either side, two
      // with a long receiver hold-off so the core backs up into the sender.
      for (int p = 0; p < PHASES; p++) begin
         write_capacity(cap_plan[p]);
         run_traffic(PHASE_ITEMS, (p % 3 == 0) ? 70 : ((p % 3 == 1) ? 50 : 30),
                     (p == 4 || p == 9), (p == 1 || p == 6) ? 20 : -1);
      end

      drain_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d gets (%0d hits, %0d misses) and %0d puts with %0d evictions",
               mirror.gets, mirror.hits, mirror.gets - mirror.hits, mirror.puts,
               mirror.evictions);
      $display("%0d capacity writes including 0, 1, 16 and 31, with stalls on both sides",
               mirror.cap_writes);
      if (mirror.errors == 0 && mirror.pending() == 0)
         $display("lru_key_value_cache_core test passed");
      else
         $display("lru_key_value_cache_core test failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_cell.sv
rtl/core/lru_key_value_cache_core.sv
rtl/core/lkvc_checker.sv
verif/testbench.sv
